// ----- src/tlc_pkg.sv -----
// Package for the tank level classifier: payload types, configuration
// struct, band and level codes, register indexes and reset values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tlc_pkg;

    // Input beat fields.
    typedef struct packed {
        logic       operation;
        logic [7:0] raw_depth;
        logic       probe_low;
        logic       probe_mid;
        logic       probe_high;
    } t_in_item;

    // Result beat fields.
    typedef struct packed {
        logic [2:0] level;
        logic [6:0] depth_cm;
    } t_out_item;

    // Configuration register file contents.
    typedef struct packed {
        logic       sensor_kind;
        logic [7:0] low_threshold;
        logic [7:0] mid_offset;
        logic [7:0] high_threshold;
        logic [7:0] low_delay;
        logic [7:0] mid_delay;
        logic [7:0] high_delay;
    } t_cfg;

    // Classification of one sample, passed from the classifier to the state logic.
    typedef struct packed {
        logic [1:0] band;
        logic [6:0] depth;
        logic       prev_in_band;
        logic [2:0] probe_level;
    } t_class;

    // Operation codes.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // Sensor kinds.
    localparam logic SENSOR_ELECTRODE = 1'b0;
    localparam logic SENSOR_PRESSURE  = 1'b1;

    // Band codes, also the index of each band's hold timer.
    localparam logic [1:0] BAND_FULL = 2'd0;
    localparam logic [1:0] BAND_MID  = 2'd1;
    localparam logic [1:0] BAND_LOW  = 2'd2;
    localparam logic [1:0] BAND_DRY  = 2'd3;

    // Reported level codes.
    localparam logic [2:0] LEVEL_FULL  = 3'd0;
    localparam logic [2:0] LEVEL_MID   = 3'd1;
    localparam logic [2:0] LEVEL_LOW   = 3'd2;
    localparam logic [2:0] LEVEL_DRY   = 3'd3;
    localparam logic [2:0] LEVEL_ERROR = 3'd4;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SENSOR_KIND    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOW_THRESHOLD  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MID_OFFSET     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_THRESHOLD = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOW_DELAY      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_MID_DELAY      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_DELAY     = 3'd6;

    // Depth clamp.
    localparam logic [6:0] DEPTH_MAX = 7'd99;

    // Configuration reset values.
    localparam t_cfg CFG_RESET = '{
        sensor_kind:    SENSOR_PRESSURE,
        low_threshold:  8'd10,
        mid_offset:     8'd30,
        high_threshold: 8'd80,
        low_delay:      8'd5,
        mid_delay:      8'd5,
        high_delay:     8'd5
    };

endpackage

`default_nettype wire

// ----- src/tlc_classify.sv -----
// Combinational classifier: clamps the depth, finds its band, judges the
// previous depth by that band's test and decodes the electrode probes.
// Depends on tlc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlc_classify (
    input  wire tlc_pkg::t_in_item i_item,
    input  wire tlc_pkg::t_cfg     i_cfg,
    input  wire logic [6:0]        i_prev_depth,
    output tlc_pkg::t_class        o_class
);

    logic [6:0] depth;
    logic [7:0] depth_x;
    logic [7:0] prev_x;
    logic [7:0] mid_threshold;
    logic [1:0] band;
    logic       prev_in_band;
    logic [2:0] probe_level;

    // Clamp the depth and derive the mid threshold modulo 256.
    assign depth = (i_item.raw_depth > {1'b0, tlc_pkg::DEPTH_MAX}) ?
                   tlc_pkg::DEPTH_MAX : i_item.raw_depth[6:0];
    assign depth_x = {1'b0, depth};
    assign prev_x  = {1'b0, i_prev_depth};
    assign mid_threshold = i_cfg.high_threshold - i_cfg.mid_offset;

    // First band test that holds, in order full, mid, low, dry.
    always_comb begin
        if (depth_x >= i_cfg.high_threshold) begin
            band = tlc_pkg::BAND_FULL;
        end else if (depth_x >= mid_threshold) begin
            band = tlc_pkg::BAND_MID;
        end else if (depth_x >= i_cfg.low_threshold) begin
            band = tlc_pkg::BAND_LOW;
        end else begin
            band = tlc_pkg::BAND_DRY;
        end
    end

    // Previous depth judged by the new band's own test.
    always_comb begin
        case (band)
            tlc_pkg::BAND_FULL: prev_in_band = (prev_x >= i_cfg.high_threshold);
            tlc_pkg::BAND_MID:  prev_in_band = (prev_x >= mid_threshold);
            tlc_pkg::BAND_LOW:  prev_in_band = (prev_x < mid_threshold) &&
                                               (prev_x >= i_cfg.low_threshold);
            default:            prev_in_band = (prev_x < i_cfg.low_threshold);
        endcase
    end

    // Electrode probe patterns; anything out of sequence is a sensor error.
    always_comb begin
        case ({i_item.probe_low, i_item.probe_mid, i_item.probe_high})
            3'b000:  probe_level = tlc_pkg::LEVEL_DRY;
            3'b100:  probe_level = tlc_pkg::LEVEL_LOW;
            3'b110:  probe_level = tlc_pkg::LEVEL_MID;
            3'b111:  probe_level = tlc_pkg::LEVEL_FULL;
            default: probe_level = tlc_pkg::LEVEL_ERROR;
        endcase
    end

    assign o_class = '{
        band:         band,
        depth:        depth,
        prev_in_band: prev_in_band,
        probe_level:  probe_level
    };

endmodule

`default_nettype wire

// ----- src/tlc_state.sv -----
// Configuration registers, set by writes, and hold timers and level state,
// updated by writes and accepted beats; forms the result of each sample.
// Depends on tlc_pkg and tlc_classify.
`timescale 1ns / 1ps
`default_nettype none

module tlc_state (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [tlc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [7:0]                   i_cfg_data,
    input  wire logic                         i_accept,
    input  wire tlc_pkg::t_in_item            i_item,
    output logic                              o_res_valid,
    output tlc_pkg::t_out_item                o_res_item
);

    tlc_pkg::t_cfg    r_cfg;
    logic [7:0]       r_timer [4];
    logic [6:0]       r_prev_depth;
    logic [1:0]       r_level;
    logic             r_seen;

    tlc_pkg::t_class  cls;
    logic             pressure_sample;
    logic [1:0]       n_level;
    logic [7:0]       preset;

    tlc_classify u_classify (
        .i_item       (i_item),
        .i_cfg        (r_cfg),
        .i_prev_depth (r_prev_depth),
        .o_class      (cls)
    );

    assign pressure_sample = i_accept && (i_item.operation == tlc_pkg::OP_SAMPLE) &&
                             (r_cfg.sensor_kind == tlc_pkg::SENSOR_PRESSURE);

    // Reload value of the band the sample falls in.
    always_comb begin
        case (cls.band)
            tlc_pkg::BAND_FULL: preset = r_cfg.high_delay;
            tlc_pkg::BAND_MID:  preset = r_cfg.mid_delay;
            default:            preset = r_cfg.low_delay;
        endcase
    end

    // Hold rule: the first sample sets the level at once, later ones move
    // only when the previous depth agreed and the band's timer ran out.
    always_comb begin
        n_level = r_level;
        if (!r_seen) begin
            n_level = cls.band;
        end else if (cls.prev_in_band && (r_timer[cls.band] == 8'd0)) begin
            n_level = cls.band;
        end
    end

    // Configuration writes and pressure state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg        <= tlc_pkg::CFG_RESET;
            r_prev_depth <= 7'd0;
            r_level      <= tlc_pkg::BAND_DRY;
            r_seen       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tlc_pkg::CFG_SENSOR_KIND:    r_cfg.sensor_kind    <= i_cfg_data[0];
                    tlc_pkg::CFG_LOW_THRESHOLD:  r_cfg.low_threshold  <= i_cfg_data;
                    tlc_pkg::CFG_MID_OFFSET:     r_cfg.mid_offset     <= i_cfg_data;
                    tlc_pkg::CFG_HIGH_THRESHOLD: r_cfg.high_threshold <= i_cfg_data;
                    tlc_pkg::CFG_LOW_DELAY:      r_cfg.low_delay      <= i_cfg_data;
                    tlc_pkg::CFG_MID_DELAY:      r_cfg.mid_delay      <= i_cfg_data;
                    tlc_pkg::CFG_HIGH_DELAY:     r_cfg.high_delay     <= i_cfg_data;
                    default: ;
                endcase
            end
            if (pressure_sample) begin
                r_level      <= n_level;
                r_seen       <= 1'b1;
                r_prev_depth <= cls.depth;
            end
        end
    end

    // Hold timers: reload on configuration writes, count down on ticks,
    // and reload the sample's band when the previous depth disagreed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer[tlc_pkg::BAND_FULL] <= tlc_pkg::CFG_RESET.high_delay;
            r_timer[tlc_pkg::BAND_MID]  <= tlc_pkg::CFG_RESET.mid_delay;
            r_timer[tlc_pkg::BAND_LOW]  <= tlc_pkg::CFG_RESET.low_delay;
            r_timer[tlc_pkg::BAND_DRY]  <= tlc_pkg::CFG_RESET.low_delay;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tlc_pkg::CFG_LOW_THRESHOLD: begin
                    r_timer[tlc_pkg::BAND_LOW] <= r_cfg.low_delay;
                    r_timer[tlc_pkg::BAND_DRY] <= r_cfg.low_delay;
                end
                tlc_pkg::CFG_MID_OFFSET: begin
                    r_timer[tlc_pkg::BAND_MID] <= r_cfg.mid_delay;
                end
                tlc_pkg::CFG_HIGH_THRESHOLD: begin
                    r_timer[tlc_pkg::BAND_MID]  <= r_cfg.mid_delay;
                    r_timer[tlc_pkg::BAND_FULL] <= r_cfg.high_delay;
                end
                tlc_pkg::CFG_LOW_DELAY: begin
                    r_timer[tlc_pkg::BAND_LOW] <= i_cfg_data;
                    r_timer[tlc_pkg::BAND_DRY] <= i_cfg_data;
                end
                tlc_pkg::CFG_MID_DELAY: begin
                    r_timer[tlc_pkg::BAND_MID] <= i_cfg_data;
                end
                tlc_pkg::CFG_HIGH_DELAY: begin
                    r_timer[tlc_pkg::BAND_FULL] <= i_cfg_data;
                end
                default: ;
            endcase
        end else if (i_accept && (i_item.operation == tlc_pkg::OP_TICK)) begin
            for (int i = 0; i < 4; i++) begin
                if (r_timer[i] != 8'd0) begin
                    r_timer[i] <= r_timer[i] - 8'd1;
                end
            end
        end else if (pressure_sample && r_seen && !cls.prev_in_band) begin
            r_timer[cls.band] <= preset;
        end
    end

    // One result per sample, none per tick.
    assign o_res_valid = i_accept && (i_item.operation == tlc_pkg::OP_SAMPLE);

    always_comb begin
        if (r_cfg.sensor_kind == tlc_pkg::SENSOR_ELECTRODE) begin
            o_res_item.level    = cls.probe_level;
            o_res_item.depth_cm = 7'd0;
        end else begin
            o_res_item.level    = {1'b0, n_level};
            o_res_item.depth_cm = cls.depth;
        end
    end

endmodule

`default_nettype wire

// ----- src/tlc_out_buf.sv -----
// Result register with a skid stage, so the input side keeps accepting
// while a finished result waits. Depends on tlc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlc_out_buf (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_res_valid,
    input  wire tlc_pkg::t_out_item i_res_item,
    output logic                    o_full,
    output logic                    o_out_valid,
    output tlc_pkg::t_out_item      o_out_item,
    input  wire logic               i_out_stall
);

    logic               r_out_valid;
    tlc_pkg::t_out_item r_out_item;
    logic               r_skid_valid;
    tlc_pkg::t_out_item r_skid_item;
    logic               out_take;

    assign out_take = r_out_valid && !i_out_stall;

    // Valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || out_take) begin
            r_out_valid <= i_res_valid;
        end else if (i_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out_item <= r_skid_item;
            end
        end else if (!r_out_valid || out_take) begin
            if (i_res_valid) begin
                r_out_item <= i_res_item;
            end
        end else if (i_res_valid) begin
            r_skid_item <= i_res_item;
        end
    end

    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

// ----- src/tank_level_classifier_with_hold_delay_core.sv -----
// A sample's result is registered (in the skid stage if stalled); a tick gives none.
// Throughput: one beat per cycle when not stalled; compares and timer updates keep up.
// A stalled output holds one result and a skid stage holds a second before input stalls.
// Reset (i_rst_n low, synchronous) loads the default configuration, timers from the
// default delays, level dry, and empties the result and skid registers.
// Depends on tlc_pkg, tlc_state, tlc_classify and tlc_out_buf.
`timescale 1ns / 1ps
`default_nettype none

module tank_level_classifier_with_hold_delay_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire tlc_pkg::t_in_item               i_in_item,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output tlc_pkg::t_out_item                   o_out_item,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [tlc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [7:0]                      i_cfg_data
);

    logic               accept;
    logic               buf_full;
    logic               res_valid;
    tlc_pkg::t_out_item res_item;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    // Input stalls only while the skid stage is occupied.
    assign o_in_stall = buf_full;
    assign accept     = i_in_valid && !buf_full;

    tlc_state u_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_item      (i_in_item),
        .o_res_valid (res_valid),
        .o_res_item  (res_item)
    );

    tlc_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res_item  (res_item),
        .o_full      (buf_full),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire

// ----- src/tlc_checker.sv -----
// Port-level checker for the tank level classifier, bound to the top level.
// Depends on tlc_pkg and tank_level_classifier_with_hold_delay_core.
`timescale 1ns / 1ps
`default_nettype none

module tlc_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire tlc_pkg::t_out_item o_out_item
);

    // The input side stalls only when a result is already waiting.
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result pending");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result beat changed");

    // Reported depth never exceeds the clamp.
    a_depth_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.depth_cm <= tlc_pkg::DEPTH_MAX))
        else $error("depth above clamp");

    // A sensor error comes only from electrode mode, which reports depth zero.
    a_error_depth_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.level == tlc_pkg::LEVEL_ERROR)
            |-> (o_out_item.depth_cm == 7'd0))
        else $error("sensor error with nonzero depth");

endmodule

bind tank_level_classifier_with_hold_delay_core tlc_checker u_tlc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

`default_nettype wire

// ----- tb/tlc_level_checker.sv -----
// Scoreboard for the tank level classifier: mirrors configuration writes and input
// beats, predicts each result beat and compares it with what the core sends.
// Depends on tlc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlc_level_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    input  wire logic                            i_in_stall,
    input  wire tlc_pkg::t_in_item               i_in_item,
    input  wire logic                            i_out_valid,
    input  wire logic                            i_out_stall,
    input  wire tlc_pkg::t_out_item              i_out_item,
    input  wire logic                            i_cfg_valid,
    input  wire logic                            i_cfg_ready,
    input  wire logic [tlc_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [7:0]                      i_cfg_data,
    output int                                   o_fail_count,
    output int                                   o_pending,
    output int                                   o_results,
    output int                                   o_samples,
    output int                                   o_ticks
);
    import tlc_pkg::*;

    // Shadow copy of the registers and of the classifier state.
    t_cfg       cfg;
    logic [7:0] hold_timer [4];
    logic [6:0] last_depth;
    logic [1:0] held_band;
    logic       got_first;
    t_out_item  level_queue [$];
    t_out_item  oldest;

    function automatic logic [7:0] mid_threshold();
        return cfg.high_threshold - cfg.mid_offset;
    endfunction

    // First band test that holds, checked from full down to dry.
    function automatic logic [1:0] band_for(input logic [6:0] depth);
        logic [7:0] dw;
        dw = {1'b0, depth};
        if (dw >= cfg.high_threshold) return BAND_FULL;
        if (dw >= mid_threshold()) return BAND_MID;
        if (dw >= cfg.low_threshold) return BAND_LOW;
        return BAND_DRY;
    endfunction

    // A band's own test, used to judge the previous depth.
    function automatic logic depth_fits(input logic [1:0] band, input logic [6:0] depth);
        logic [7:0] dw;
        dw = {1'b0, depth};
        case (band)
            BAND_FULL: return dw >= cfg.high_threshold;
            BAND_MID:  return dw >= mid_threshold();
            BAND_LOW:  return dw < mid_threshold() && dw >= cfg.low_threshold;
            default:   return dw < cfg.low_threshold;
        endcase
    endfunction

    function automatic logic [7:0] reload_delay(input logic [1:0] band);
        if (band == BAND_FULL) return cfg.high_delay;
        if (band == BAND_MID) return cfg.mid_delay;
        return cfg.low_delay;
    endfunction

    task automatic note_mismatch(input string msg);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    task automatic reset_prediction();
        cfg                   = CFG_RESET;
        hold_timer[BAND_FULL] = CFG_RESET.high_delay;
        hold_timer[BAND_MID]  = CFG_RESET.mid_delay;
        hold_timer[BAND_LOW]  = CFG_RESET.low_delay;
        hold_timer[BAND_DRY]  = CFG_RESET.low_delay;
        last_depth            = '0;
        held_band             = BAND_DRY;
        got_first             = 1'b0;
        level_queue.delete();
        o_fail_count          = 0;
        o_results             = 0;
        o_samples             = 0;
        o_ticks               = 0;
    endtask

    // Every write reloads the timers that depend on the register, even if unchanged.
    task automatic apply_write(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] data);
        case (idx)
            CFG_SENSOR_KIND: begin
                cfg.sensor_kind = data[0];
            end
            CFG_LOW_THRESHOLD: begin
                cfg.low_threshold     = data;
                hold_timer[BAND_LOW]  = cfg.low_delay;
                hold_timer[BAND_DRY]  = cfg.low_delay;
            end
            CFG_MID_OFFSET: begin
                cfg.mid_offset        = data;
                hold_timer[BAND_MID]  = cfg.mid_delay;
            end
            CFG_HIGH_THRESHOLD: begin
                cfg.high_threshold    = data;
                hold_timer[BAND_MID]  = cfg.mid_delay;
                hold_timer[BAND_FULL] = cfg.high_delay;
            end
            CFG_LOW_DELAY: begin
                cfg.low_delay         = data;
                hold_timer[BAND_LOW]  = data;
                hold_timer[BAND_DRY]  = data;
            end
            CFG_MID_DELAY: begin
                cfg.mid_delay         = data;
                hold_timer[BAND_MID]  = data;
            end
            CFG_HIGH_DELAY: begin
                cfg.high_delay        = data;
                hold_timer[BAND_FULL] = data;
            end
            default: begin
            end
        endcase
    endtask

    // Works out the effect of one input beat and queues the result it causes.
    task automatic predict_beat(input t_in_item item);
        t_out_item  want;
        logic [6:0] depth;
        logic [1:0] band;
        int         k;
        if (item.operation == OP_TICK) begin
            o_ticks++;
            for (k = 0; k < 4; k++) begin
                if (hold_timer[k] != 8'd0) hold_timer[k]--;
            end
            return;
        end
        o_samples++;
        if (cfg.sensor_kind == SENSOR_ELECTRODE) begin
            // Probes map straight to a level; the pressure state is left alone.
            case ({item.probe_low, item.probe_mid, item.probe_high})
                3'b000:  want.level = LEVEL_DRY;
                3'b100:  want.level = LEVEL_LOW;
                3'b110:  want.level = LEVEL_MID;
                3'b111:  want.level = LEVEL_FULL;
                default: want.level = LEVEL_ERROR;
            endcase
            want.depth_cm = '0;
        end else begin
            depth = (item.raw_depth > DEPTH_MAX) ? DEPTH_MAX : item.raw_depth[6:0];
            band  = band_for(depth);
            if (!got_first) begin
                // The first pressure sample sets the level without any hold.
                held_band = band;
                got_first = 1'b1;
            end else if (depth_fits(band, last_depth)) begin
                if (hold_timer[band] == 8'd0) held_band = band;
            end else begin
                hold_timer[band] = reload_delay(band);
            end
            last_depth    = depth;
            want.level    = {1'b0, held_band};
            want.depth_cm = depth;
        end
        level_queue.push_back(want);
    endtask

    // Results are checked before new beats are predicted: a result never leaves in
    // the cycle its sample is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_prediction();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                o_results++;
                if (level_queue.size() == 0) begin
                    note_mismatch($sformatf("unexpected result beat: level %0d depth %0d",
                                            i_out_item.level, i_out_item.depth_cm));
                end else begin
                    oldest = level_queue.pop_front();
                    if (i_out_item.level !== oldest.level ||
                        i_out_item.depth_cm !== oldest.depth_cm) begin
                        note_mismatch($sformatf(
                            "result mismatch: level %0d (expected %0d), depth %0d (expected %0d)",
                            i_out_item.level, oldest.level, i_out_item.depth_cm,
                            oldest.depth_cm));
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                apply_write(i_cfg_index, i_cfg_data);
            end
            if (i_in_valid && !i_in_stall) begin
                predict_beat(i_in_item);
            end
        end
        o_pending = level_queue.size();
    end

endmodule

`default_nettype wire

// ----- tb/tank_level_classifier_with_hold_delay_core_tb.sv -----
// Top of the tank level classifier testbench: clock, reset, stimulus and verdict.
// Depends on tlc_pkg, tank_level_classifier_with_hold_delay_core and tlc_level_checker.
`timescale 1ns / 1ps
`default_nettype none

module tank_level_classifier_with_hold_delay_core_tb;
    import tlc_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 3'd7;
    localparam int PHASES          = 9;
    localparam int BEATS_PER_PHASE = 220;
    localparam logic [7:0] OPENING_DEPTHS [9] = '{8'd0, 8'd10, 8'd10, 8'd9, 8'd50,
                                                  8'd80, 8'd100, 8'd79, 8'd99};

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    t_in_item               in_item   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    t_out_item              out_item;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [7:0]             cfg_data  = '0;

    int fail_count;
    int pending;
    int results;
    int samples;
    int ticks;

    // Traffic shaping shared between the sender and the receiver process.
    int         idle_pct     = 0;
    int         stall_pct    = 0;
    int         hold_len     = 0;
    int         hold_seq     = 0;
    t_cfg       live_cfg     = CFG_RESET;
    logic [7:0] recent_depth = '0;

    tank_level_classifier_with_hold_delay_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    tlc_level_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results),
        .o_samples    (samples),
        .o_ticks      (ticks)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Receiver: random stalls, or a long hold whenever a new one is requested.
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        forever begin
            @(negedge clk);
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                hold_left = hold_len;
            end
            if (hold_left > 0) begin
                out_stall = 1'b1;
                hold_left--;
            end else begin
                out_stall = ($urandom_range(99) < stall_pct);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Timeout: results still outstanding: %0d", pending);
        $display("Verification failed");
        $finish;
    end

    function automatic t_in_item sample_of(input logic [7:0] depth);
        t_in_item item;
        item           = '0;
        item.operation = OP_SAMPLE;
        item.raw_depth = depth;
        {item.probe_low, item.probe_mid, item.probe_high} = 3'($urandom_range(7));
        return item;
    endfunction

    function automatic t_in_item tick_of(input logic [7:0] depth, input logic [2:0] probes);
        t_in_item item;
        item           = '0;
        item.operation = OP_TICK;
        item.raw_depth = depth;
        {item.probe_low, item.probe_mid, item.probe_high} = probes;
        return item;
    endfunction

    // Offers one beat after a random gap and holds it until the core takes it.
    task automatic send_item(input t_in_item item);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_item  = item;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Drains every expected result, then allows for a tick still in flight.
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        wait (pending == 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    initial begin
        t_cfg     phase_cfg;
        t_in_item item;
        int       base;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: clamped first sample, a held change, release after ticks.
        send_item(sample_of(8'd255));
        send_item(sample_of(8'd0));
        send_item(sample_of(8'd0));
        repeat (4) send_item(tick_of(8'd0, 3'b000));
        send_item(tick_of(8'd255, 3'b111));
        foreach (OPENING_DEPTHS[k]) begin
            send_item(sample_of(OPENING_DEPTHS[k]));
        end

        // Electrode mode: every probe pattern, valid and invalid.
        wait_idle();
        write_reg(CFG_SENSOR_KIND, {7'd0, SENSOR_ELECTRODE});
        live_cfg.sensor_kind = SENSOR_ELECTRODE;
        for (int pat = 0; pat < 8; pat++) begin
            item = sample_of(8'($urandom_range(255)));
            {item.probe_low, item.probe_mid, item.probe_high} = pat[2:0];
            send_item(item);
        end

        for (int p = 0; p < PHASES; p++) begin
            // Random settings with short hold delays, overridden by the fixed corners.
            phase_cfg.sensor_kind    = (p == 3 || p == 7) ? SENSOR_ELECTRODE : SENSOR_PRESSURE;
            phase_cfg.low_threshold  = 8'($urandom_range(60));
            phase_cfg.mid_offset     = 8'($urandom_range(1) ? $urandom_range(255)
                                                            : $urandom_range(60));
            phase_cfg.high_threshold = 8'($urandom_range(120));
            phase_cfg.low_delay      = 8'($urandom_range(6));
            phase_cfg.mid_delay      = 8'($urandom_range(6));
            phase_cfg.high_delay     = 8'($urandom_range(6));
            case (p)
                0: begin
                    phase_cfg = CFG_RESET;
                end
                1: begin
                    phase_cfg             = '0;
                    phase_cfg.sensor_kind = SENSOR_PRESSURE;
                end
                2: begin
                    phase_cfg = '1;
                end
                4: begin
                    // Thresholds out of order are applied as they stand.
                    phase_cfg.low_threshold  = 8'd90;
                    phase_cfg.mid_offset     = 8'd200;
                    phase_cfg.high_threshold = 8'd20;
                end
                default: begin
                end
            endcase

            wait_idle();
            write_reg(CFG_SENSOR_KIND, {7'd0, phase_cfg.sensor_kind});
            write_reg(CFG_LOW_THRESHOLD, phase_cfg.low_threshold);
            write_reg(CFG_MID_OFFSET, phase_cfg.mid_offset);
            write_reg(CFG_HIGH_THRESHOLD, phase_cfg.high_threshold);
            write_reg(CFG_LOW_DELAY, phase_cfg.low_delay);
            write_reg(CFG_MID_DELAY, phase_cfg.mid_delay);
            write_reg(CFG_HIGH_DELAY, phase_cfg.high_delay);
            if (p % 2 == 1) begin
                write_reg(CFG_UNUSED_INDEX, 8'($urandom_range(255)));
            end
            live_cfg = phase_cfg;

            case (p % 4)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 65;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 65;
                end
                default: begin
                    idle_pct  = 13;
                    stall_pct = 13;
                end
            endcase

            // Mostly samples; some near thresholds, some repeated so holds expire.
            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                item.operation = ($urandom_range(99) < 30) ? OP_TICK : OP_SAMPLE;
                case ($urandom_range(4))
                    0: begin
                        item.raw_depth = 8'($urandom_range(255));
                    end
                    1: begin
                        case ($urandom_range(2))
                            0:       base = live_cfg.low_threshold;
                            1:       base = live_cfg.high_threshold - live_cfg.mid_offset;
                            default: base = live_cfg.high_threshold;
                        endcase
                        item.raw_depth = 8'(base + $urandom_range(4) - 2);
                    end
                    2: begin
                        item.raw_depth = 8'($urandom_range(99));
                    end
                    3: begin
                        case ($urandom_range(3))
                            0:       item.raw_depth = 8'd0;
                            1:       item.raw_depth = 8'd99;
                            2:       item.raw_depth = 8'd100;
                            default: item.raw_depth = 8'd255;
                        endcase
                    end
                    default: begin
                        item.raw_depth = recent_depth;
                    end
                endcase
                {item.probe_low, item.probe_mid, item.probe_high} = 3'($urandom_range(7));
                if (item.operation == OP_SAMPLE) begin
                    recent_depth = item.raw_depth;
                end
                send_item(item);
            end

            // Long receiver hold with a steady sender, so the core backs up its input.
            if (p == 4) begin
                idle_pct = 0;
                hold_len = 80;
                hold_seq++;
                repeat (24) send_item(sample_of(8'($urandom_range(255))));
            end
        end

        idle_pct  = 0;
        stall_pct = 0;
        wait_idle();
        repeat (8) @(posedge clk);
        $display("Covered %0d input beats (%0d samples, %0d ticks) and %0d result beats",
                 samples + ticks, samples, ticks, results);
        $display("over %0d register settings, both sensor kinds and a long output hold.",
                 PHASES + 2);
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
